>>> rtl/piq_pkg.sv
// piq_pkg: shared types and codes for the positional insert queue
`timescale 1ns / 1ps
package piq_pkg;

  // request codes carried in req_type
  typedef enum logic [1:0] {
    REQ_APPEND = 2'd0,
    REQ_INSERT = 2'd1,
    REQ_REMOVE = 2'd2,
    REQ_QUERY  = 2'd3
  } piq_req_e_t;

  // one stored record
  typedef struct packed {
    logic [63:0] name;
    logic [15:0] start;
    logic [15:0] duration;
  } piq_rec_t;

  // operation applied to the cell row
  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_PLACE  = 2'd1,
    OP_DROP   = 2'd2,
    OP_REJECT = 2'd3
  } piq_op_t;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_EXEC = 2'd1,
    ST_RESP = 2'd2
  } piq_state_t;

  // controller to datapath
  typedef struct packed {
    logic    capture;
    logic    execute;
    piq_op_t op;
  } piq_cmd_t;

  // datapath to controller
  typedef struct packed {
    piq_req_e_t req;
    logic       pos_zero;
    logic       full;
    logic       empty;
  } piq_status_t;

endpackage

>>> rtl/piq_req_if.sv
// piq_req_if: request channel with valid/ready handshake
`timescale 1ns / 1ps
interface piq_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [63:0] item_name;
  logic [15:0] item_start;
  logic [15:0] item_duration;
  logic [7:0]  position;

  modport source (output valid, req_type, item_name, item_start, item_duration, position,
                  input ready);
  modport sink (input valid, req_type, item_name, item_start, item_duration, position,
                output ready);
endinterface

>>> rtl/piq_rsp_if.sv
// piq_rsp_if: response channel with valid/ready handshake
`timescale 1ns / 1ps
interface piq_rsp_if;
  logic        valid;
  logic        ready;
  logic [63:0] head_name;
  logic [15:0] head_start;
  logic [15:0] head_duration;
  logic [4:0]  fill_count;
  logic        queue_empty;
  logic        rejected;

  modport source (output valid, head_name, head_start, head_duration, fill_count,
                  queue_empty, rejected, input ready);
  modport sink (input valid, head_name, head_start, head_duration, fill_count,
                queue_empty, rejected, output ready);
endinterface

>>> rtl/piq_ctrl.sv
// piq_ctrl: request sequencing state machine for the positional insert queue
`timescale 1ns / 1ps
module piq_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_ready,
  output logic                 rsp_valid,
  input  logic                 rsp_ready,
  input  piq_pkg::piq_status_t status,
  output piq_pkg::piq_cmd_t    cmd
);
  import piq_pkg::*;

  piq_state_t state;
  piq_state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next  = state;
    req_ready   = 1'b0;
    rsp_valid   = 1'b0;
    cmd.capture = 1'b0;
    cmd.execute = 1'b0;
    cmd.op      = OP_HOLD;
    unique case (state)
      ST_IDLE: begin
        req_ready   = 1'b1;
        cmd.capture = req_valid;
        if (req_valid) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.execute = 1'b1;
        // pick the row operation from the captured request
        case (status.req)
          REQ_APPEND: cmd.op = status.full ? OP_REJECT : OP_PLACE;
          REQ_INSERT: begin
            if (status.pos_zero) begin
              cmd.op = OP_HOLD;
            end else begin
              cmd.op = status.full ? OP_REJECT : OP_PLACE;
            end
          end
          REQ_REMOVE: cmd.op = status.empty ? OP_HOLD : OP_DROP;
          default:    cmd.op = OP_HOLD;
        endcase
        state_next = ST_RESP;
      end
      ST_RESP: begin
        rsp_valid = 1'b1;
        if (rsp_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  // never take a request while a response is pending
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(req_ready && rsp_valid))
    else $error("request accepted while response pending");

  // an accepted request is executed in the next cycle
  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> (state == ST_EXEC))
    else $error("accepted request not executed");

  // execution always leads straight to the response
  a_exec_resp: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EXEC) |=> (state == ST_RESP))
    else $error("execute not followed by response");
`endif

endmodule

>>> rtl/piq_datapath.sv
// piq_datapath: shifting cell row, fill count and response fields
`timescale 1ns / 1ps
module piq_datapath #(
  parameter int DEPTH = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  piq_pkg::piq_cmd_t    cmd,
  output piq_pkg::piq_status_t status,
  input  logic [1:0]           req_type,
  input  logic [63:0]          item_name,
  input  logic [15:0]          item_start,
  input  logic [15:0]          item_duration,
  input  logic [7:0]           position,
  output logic [63:0]          head_name,
  output logic [15:0]          head_start,
  output logic [15:0]          head_duration,
  output logic [4:0]           fill_count,
  output logic                 queue_empty,
  output logic                 rejected
);
  import piq_pkg::*;

  localparam int CW   = $clog2(DEPTH + 1);
  localparam int IW   = $clog2(DEPTH);
  localparam int CMPW = (CW > 8) ? CW : 8;

  piq_req_e_t     req_r;
  logic [7:0]     pos_r;
  piq_rec_t       rec_r;
  piq_rec_t       row [DEPTH];
  logic [CW-1:0]  count;
  logic [IW-1:0]  place_idx;
  logic           beyond;

  // capture the accepted request
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r          <= piq_req_e_t'(req_type);
      pos_r          <= position;
      rec_r.name     <= item_name;
      rec_r.start    <= item_start;
      rec_r.duration <= item_duration;
    end
  end

  // target slot: tail for append or a position past the count
  assign beyond = (CMPW'(pos_r) > CMPW'(count));
  always_comb begin
    if (req_r == REQ_INSERT && !beyond) begin
      place_idx = IW'(pos_r - 8'd1);
    end else begin
      place_idx = IW'(count);
    end
  end

  // status for the controller
  assign status.req      = req_r;
  assign status.pos_zero = (pos_r == 8'd0);
  assign status.full     = (count == CW'(DEPTH));
  assign status.empty    = (count == '0);

  // cell row: each slot holds, loads the new record, or takes a neighbor
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    always_ff @(posedge clk) begin
      if (cmd.op == OP_PLACE) begin
        if (IW'(i) == place_idx) begin
          row[i] <= rec_r;
        end else if (IW'(i) > place_idx) begin
          row[i] <= row[(i > 0) ? i - 1 : 0];
        end
      end else if (cmd.op == OP_DROP && i < DEPTH - 1) begin
        row[i] <= row[(i < DEPTH - 1) ? i + 1 : i];
      end
    end
  end

  // fill count and reject flag
  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      rejected <= 1'b0;
    end else if (cmd.execute) begin
      rejected <= (cmd.op == OP_REJECT);
      if (cmd.op == OP_PLACE) begin
        count <= count + CW'(1);
      end else if (cmd.op == OP_DROP) begin
        count <= count - CW'(1);
      end
    end
  end

  // response fields: head reads as zero when empty
  assign queue_empty   = (count == '0);
  assign head_name     = queue_empty ? 64'd0 : row[0].name;
  assign head_start    = queue_empty ? 16'd0 : row[0].start;
  assign head_duration = queue_empty ? 16'd0 : row[0].duration;
  assign fill_count    = 5'(count);

`ifndef SYNTHESIS
  // count never passes the capacity
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("fill count above capacity");

  // a rejected record leaves the count unchanged and raises the flag
  a_reject_stable: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_REJECT) |=> ($stable(count) && rejected))
    else $error("reject changed the queue");

  // a drop removes exactly one record
  a_drop_count: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_DROP) |=> (count == $past(count) - CW'(1)))
    else $error("drop did not decrement count");
`endif

endmodule

>>> rtl/positional_insert_queue.sv
// positional_insert_queue: top level joining controller and datapath
//
// Bounded ordered queue of DEPTH records (name, start time, duration).
// The req channel carries one request per transfer: append at the tail,
// insert at a 1-based position (a position past the count appends, position
// zero is ignored), remove the head, or query only. Each request yields
// exactly one transfer on the rsp channel with the head record after the
// request (zero when empty), the fill count, an empty flag and a reject flag
// set when an append or a nonzero-position insert met a full queue.
// Latency: the request is captured at its transfer, the cell row shifts in
// the next cycle, and the response is valid in the cycle after that.
// The three-state controller (capture, execute, respond) handles one
// request at a time: a new request is taken only after the last response
// has transferred; the row itself shifts all slots together.
// While the receiver stalls the response holds and req.ready stays low.
// Reset (rst, synchronous) empties the queue and returns to idle; slot
// contents are not cleared and are never read while unoccupied.
`timescale 1ns / 1ps
module positional_insert_queue #(
  parameter int DEPTH = 16
) (
  input logic     clk,
  input logic     rst,
  piq_req_if.sink   req,
  piq_rsp_if.source rsp
);
  import piq_pkg::*;

  piq_cmd_t    cmd;
  piq_status_t status;

  // request sequencing
  piq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .status    (status),
    .cmd       (cmd)
  );

  // record storage and response fields
  piq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .req_type      (req.req_type),
    .item_name     (req.item_name),
    .item_start    (req.item_start),
    .item_duration (req.item_duration),
    .position      (req.position),
    .head_name     (rsp.head_name),
    .head_start    (rsp.head_start),
    .head_duration (rsp.head_duration),
    .fill_count    (rsp.fill_count),
    .queue_empty   (rsp.queue_empty),
    .rejected      (rsp.rejected)
  );

endmodule

>>> sim/positional_insert_queue_test.sv
// positional_insert_queue_test: self-checking testbench for the positional insert queue
`timescale 1ns / 1ps
module positional_insert_queue_test;
  import piq_pkg::*;

  localparam int DEPTH        = 16;
  localparam int RAND_ITEMS   = 775;
  localparam int HOLD_CYCLES  = 80;
  localparam int IDLE_PCT     = 25;
  localparam int SILENT_LIMIT = 1000;
  localparam int DIR_ROWS     = 25;

  // one request as offered on the request channel
  typedef struct packed {
    piq_req_e_t  kind;
    logic [63:0] name;
    logic [15:0] start;
    logic [15:0] dur;
    logic [7:0]  pos;
  } queue_req_t;

  // one response: head record and status after a request
  typedef struct packed {
    logic [63:0] name;
    logic [15:0] start;
    logic [15:0] dur;
    logic [4:0]  fill;
    logic        empty;
    logic        rej;
  } queue_rsp_t;

  // directed row: request plus an optional hand-written response
  typedef struct packed {
    queue_req_t rq;
    logic       typed;
    queue_rsp_t rs;
  } dir_row_t;

  logic clk;
  logic rst;

  piq_req_if req_ch ();
  piq_rsp_if rsp_ch ();

  positional_insert_queue #(.DEPTH(DEPTH)) DUT (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // records the queue should hold, head first
  piq_rec_t   held_recs[$];
  // responses still owed by the block, oldest first
  queue_rsp_t expected_heads[$];

  int errors;
  int checked;
  int rejects_seen;
  int zero_pos_inserts;
  int peak_fill;
  int kind_count[4];
  int silent_cycles;
  int hold_asks;
  int hold_done;
  int hold_left;
  bit no_idle;

  // directed table: empty-queue cases, head and tail extremes, fill to full, full-queue cases
  dir_row_t dir_tab [DIR_ROWS] = '{
    '{'{REQ_QUERY,  64'h0,                  16'h0,    16'h0,    8'h00}, 1'b1,
      '{64'h0, 16'h0, 16'h0, 5'd0, 1'b1, 1'b0}},
    '{'{REQ_REMOVE, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF, 16'hFFFF, 8'hFF}, 1'b1,
      '{64'h0, 16'h0, 16'h0, 5'd0, 1'b1, 1'b0}},
    '{'{REQ_INSERT, 64'hA5A5_A5A5_A5A5_A5A5, 16'h1234, 16'h5678, 8'h00}, 1'b1,
      '{64'h0, 16'h0, 16'h0, 5'd0, 1'b1, 1'b0}},
    '{'{REQ_APPEND, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF, 16'hFFFF, 8'h00}, 1'b1,
      '{64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF, 16'hFFFF, 5'd1, 1'b0, 1'b0}},
    '{'{REQ_INSERT, 64'h0,                  16'h0,    16'h0,    8'h01}, 1'b1,
      '{64'h0, 16'h0, 16'h0, 5'd2, 1'b0, 1'b0}},
    '{'{REQ_INSERT, 64'h5441_494C_504F_5331, 16'h0100, 16'h0010, 8'hFF}, 1'b0, '0},
    '{'{REQ_INSERT, 64'h4D49_4444_4C45_5F32, 16'h0200, 16'h0020, 8'h02}, 1'b0, '0},
    '{'{REQ_INSERT, 64'h4154_434F_554E_5434, 16'h0300, 16'h0030, 8'h04}, 1'b0, '0},
    '{'{REQ_QUERY,  64'hDEAD_BEEF_DEAD_BEEF, 16'hAAAA, 16'h5555, 8'hFF}, 1'b0, '0},
    '{'{REQ_REMOVE, 64'h0123_4567_89AB_CDEF, 16'h5555, 16'hAAAA, 8'h01}, 1'b0, '0},
    '{'{REQ_INSERT, 64'h5041_5354_454E_4435, 16'h0400, 16'h0040, 8'h05}, 1'b0, '0},
    '{'{REQ_APPEND, 64'h0000_0000_0000_0001, 16'h0001, 16'h0001, 8'h07}, 1'b0, '0},
    '{'{REQ_INSERT, 64'h8000_0000_0000_0000, 16'h8000, 16'h8000, 8'h01}, 1'b0, '0},
    '{'{REQ_INSERT, 64'h3333_3333_3333_3333, 16'h3333, 16'h3333, 8'h03}, 1'b0, '0},
    '{'{REQ_APPEND, 64'hCCCC_CCCC_CCCC_CCCC, 16'hCCCC, 16'hCCCC, 8'h80}, 1'b0, '0},
    '{'{REQ_INSERT, 64'h7777_7777_7777_7777, 16'h7777, 16'h7777, 8'h80}, 1'b0, '0},
    '{'{REQ_INSERT, 64'h9999_9999_9999_9999, 16'h9999, 16'h9999, 8'h09}, 1'b0, '0},
    '{'{REQ_APPEND, 64'h1111_2222_3333_4444, 16'h1111, 16'h2222, 8'h00}, 1'b0, '0},
    '{'{REQ_INSERT, 64'h4444_3333_2222_1111, 16'h4444, 16'h3333, 8'h01}, 1'b0, '0},
    '{'{REQ_INSERT, 64'h6666_6666_6666_6666, 16'h6666, 16'h6666, 8'h0D}, 1'b0, '0},
    '{'{REQ_APPEND, 64'hEEEE_EEEE_EEEE_EEEE, 16'hEEEE, 16'hEEEE, 8'h00}, 1'b0, '0},
    '{'{REQ_INSERT, 64'hBBBB_BBBB_BBBB_BBBB, 16'hBBBB, 16'hBBBB, 8'h08}, 1'b0, '0},
    '{'{REQ_APPEND, 64'hF0F0_F0F0_F0F0_F0F0, 16'hF0F0, 16'hF0F0, 8'h00}, 1'b0, '0},
    '{'{REQ_INSERT, 64'h0F0F_0F0F_0F0F_0F0F, 16'h0F0F, 16'h0F0F, 8'h03}, 1'b0, '0},
    '{'{REQ_INSERT, 64'h5A5A_5A5A_5A5A_5A5A, 16'h5A5A, 16'h5A5A, 8'h00}, 1'b0, '0}
  };

  // clock
  initial clk = 1'b0;
  always #6 clk = ~clk;

  // apply one request to the held records and return the response it should give
  function automatic queue_rsp_t queue_after_request(queue_req_t it);
    piq_rec_t   rec;
    queue_rsp_t r;
    r = '0;
    rec.name = it.name;
    rec.start = it.start;
    rec.duration = it.dur;
    case (it.kind)
      REQ_APPEND: begin
        if (held_recs.size() >= DEPTH) r.rej = 1'b1;
        else held_recs.push_back(rec);
      end
      REQ_INSERT: begin
        // position zero leaves everything alone, even on a full queue
        if (it.pos != 8'd0) begin
          if (held_recs.size() >= DEPTH) r.rej = 1'b1;
          else if (int'(it.pos) > held_recs.size()) held_recs.push_back(rec);
          else held_recs.insert(int'(it.pos) - 1, rec);
        end
      end
      REQ_REMOVE: begin
        if (held_recs.size() != 0) void'(held_recs.pop_front());
      end
      default: ;
    endcase
    if (held_recs.size() != 0) begin
      r.name = held_recs[0].name;
      r.start = held_recs[0].start;
      r.dur = held_recs[0].duration;
    end
    r.fill = 5'(held_recs.size());
    r.empty = (held_recs.size() == 0);
    return r;
  endfunction

  // random request, biased toward filling or draining the queue
  function automatic queue_req_t random_request(bit filling);
    queue_req_t it;
    int         n;
    int         roll;
    n = held_recs.size();
    roll = $urandom_range(99);
    if (filling)
      it.kind = (roll < 35) ? REQ_APPEND : (roll < 75) ? REQ_INSERT :
                (roll < 90) ? REQ_REMOVE : REQ_QUERY;
    else
      it.kind = (roll < 10) ? REQ_APPEND : (roll < 25) ? REQ_INSERT :
                (roll < 90) ? REQ_REMOVE : REQ_QUERY;
    case ($urandom_range(7))
      0:       it.name = '0;
      1:       it.name = '1;
      default: it.name = {$urandom, $urandom};
    endcase
    it.start = 16'($urandom_range(65535));
    it.dur = 16'($urandom_range(65535));
    if (it.kind == REQ_INSERT) begin
      case ($urandom_range(9))
        0:       it.pos = 8'd0;
        1:       it.pos = 8'd1;
        2:       it.pos = 8'(n);
        3:       it.pos = 8'(n + 1);
        4:       it.pos = 8'd255;
        5:       it.pos = 8'($urandom_range(255, 1));
        default: it.pos = 8'($urandom_range(n + 1, 1));
      endcase
    end else begin
      it.pos = 8'($urandom_range(255));
    end
    return it;
  endfunction

  // offer one request, wait for its transfer, then record what it should return
  task automatic offer(queue_req_t it, logic typed, queue_rsp_t typed_rsp);
    queue_rsp_t want;
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.req_type <= it.kind;
    req_ch.item_name <= it.name;
    req_ch.item_start <= it.start;
    req_ch.item_duration <= it.dur;
    req_ch.position <= it.pos;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    want = queue_after_request(it);
    expected_heads.push_back(typed ? typed_rsp : want);
    kind_count[it.kind]++;
    if (it.kind == REQ_INSERT && it.pos == 8'd0) zero_pos_inserts++;
    if (want.rej) rejects_seen++;
    if (held_recs.size() > peak_fill) peak_fill = held_recs.size();
  endtask

  task automatic check_field(string fname, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, fname, want, got);
    end
  endtask

  // response side: random stalls plus one long hold-off on request
  initial begin
    rsp_ch.ready = 1'b0;
    hold_done = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else if (hold_done != hold_asks) begin
        hold_done = hold_asks;
        hold_left = HOLD_CYCLES - 1;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // compare every response transfer with the oldest expectation
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (expected_heads.size() == 0) begin
        errors++;
        $display("%0t: response with nothing expected, got head %0h fill %0d",
                 $time, rsp_ch.head_name, rsp_ch.fill_count);
      end else begin
        queue_rsp_t want;
        want = expected_heads.pop_front();
        checked++;
        check_field("head_name", want.name, rsp_ch.head_name);
        check_field("head_start", 64'(want.start), 64'(rsp_ch.head_start));
        check_field("head_duration", 64'(want.dur), 64'(rsp_ch.head_duration));
        check_field("fill_count", 64'(want.fill), 64'(rsp_ch.fill_count));
        check_field("queue_empty", 64'(want.empty), 64'(rsp_ch.queue_empty));
        check_field("rejected", 64'(want.rej), 64'(rsp_ch.rejected));
      end
    end
  end

  // watchdog: give up when no transfer happens for too long
  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      silent_cycles <= 0;
    end else if (silent_cycles >= SILENT_LIMIT) begin
      $display("%0t: no transfer for %0d cycles, %0d responses outstanding",
               $time, SILENT_LIMIT, expected_heads.size());
      $display("positional_insert_queue_test: done, errors");
      $finish;
    end else begin
      silent_cycles <= silent_cycles + 1;
    end
  end

  // stimulus
  initial begin
    queue_req_t it;
    errors = 0;
    checked = 0;
    rejects_seen = 0;
    zero_pos_inserts = 0;
    peak_fill = 0;
    silent_cycles = 0;
    hold_asks = 0;
    no_idle = 1'b0;
    foreach (kind_count[k]) kind_count[k] = 0;
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.req_type = REQ_QUERY;
    req_ch.item_name = '0;
    req_ch.item_start = '0;
    req_ch.item_duration = '0;
    req_ch.position = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed part
    foreach (dir_tab[r]) offer(dir_tab[r].rq, dir_tab[r].typed, dir_tab[r].rs);

    // random part in fill and drain phases
    for (int i = 0; i < RAND_ITEMS; i++) begin
      // long receiver hold-off while requests keep coming
      if (i == 150) hold_asks++;
      // let the block drain completely before going on
      if (i == 350) begin
        req_ch.valid <= 1'b0;
        while (expected_heads.size() != 0) @(posedge clk);
      end
      no_idle = (i >= 450 && i < 600);
      it = random_request(((i / 40) % 2) == 1);
      offer(it, 1'b0, '0);
    end
    req_ch.valid <= 1'b0;

    while (expected_heads.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("covered %0d appends, %0d inserts (%0d at position zero), %0d removes, %0d queries",
             kind_count[REQ_APPEND], kind_count[REQ_INSERT], zero_pos_inserts,
             kind_count[REQ_REMOVE], kind_count[REQ_QUERY]);
    $display("%0d responses checked, %0d full-queue rejects, peak fill %0d of %0d",
             checked, rejects_seen, peak_fill, DEPTH);
    if (errors == 0)
      $display("positional_insert_queue_test: done, clean");
    else
      $display("positional_insert_queue_test: done, errors");
    $finish;
  end

endmodule
